/* rtl/rotated_sprite_quad_vertices_top_assert.svh */
// assertion macros for the rotated sprite quad vertex block
// expects clk and rst in scope at the point of use
`ifndef ROTATED_SPRITE_QUAD_VERTICES_TOP_ASSERT_SVH
`define ROTATED_SPRITE_QUAD_VERTICES_TOP_ASSERT_SVH

// property holds at every edge outside reset
`define RSQV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies outcome in the next
`define RSQV_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

/* rtl/rsqv_pkg.sv */
// shared types and constants for the rotated sprite quad vertex block
// no dependencies
package rsqv_pkg;

  localparam int CORDIC_W   = 34;  // cordic datapath, headroom over q16.16
  localparam int ATAN_COUNT = 24;

  localparam logic [15:0] SCALE_07_Q16 = 16'd45875;        // 0.7 in q0.16
  localparam logic [31:0] GAIN_Q32     = 32'd2608131496;   // cordic gain in q0.32
  localparam logic [15:0] ANGLE_OFFSET = 16'd8192;         // eighth turn
  localparam logic signed [15:0] QUARTER_POS = 16'sd16384;
  localparam logic signed [15:0] QUARTER_NEG = -16'sd16384;

  // arctangent of 2^-i, 2^32 units per turn
  localparam logic [29:0] ATAN_UNITS [ATAN_COUNT] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4,
    30'h028B0D43, 30'h0145D7E1, 30'h00A2F61E, 30'h00517C55,
    30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2F9, 30'h0000517C,
    30'h000028BE, 30'h0000145F, 30'h00000A2F, 30'h00000517,
    30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051
  };

  // fields that ride along the pipeline untouched
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [31:0]        cz;
    logic [31:0]        colour;
  } side_t;

endpackage

/* rtl/rsqv_prescale.sv */
// size scaling, gain pre-multiply and angle folding, four register stages
// depends on rsqv_pkg
module rsqv_prescale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [30:0]          sprite_size,
  input  logic [15:0]          rotation,
  input  rsqv_pkg::side_t      in_side,
  output logic                 out_valid,
  output logic [30:0]          x0,
  output logic signed [15:0]   angle,
  output logic                 flip,
  output rsqv_pkg::side_t      out_side
);

  logic [3:0]             vld;
  logic [46:0]            prod1;
  logic [30:0]            scaled;
  logic [62:0]            prod2;
  logic signed [15:0]     ang [4];
  logic                   flp [4];
  rsqv_pkg::side_t        sd  [4];

  logic signed [15:0]     a_raw;
  logic                   a_flip;

  always_comb begin
    a_raw  = $signed(rotation - rsqv_pkg::ANGLE_OFFSET);
    a_flip = (a_raw > rsqv_pkg::QUARTER_POS) || (a_raw < rsqv_pkg::QUARTER_NEG);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // moving by a half turn is a flip of the top bit in 16-bit units
      prod1  <= 47'(sprite_size) * 47'(rsqv_pkg::SCALE_07_Q16);
      ang[0] <= a_flip ? {~a_raw[15], a_raw[14:0]} : a_raw;
      flp[0] <= a_flip;
      sd[0]  <= in_side;

      scaled <= 31'((prod1 + 47'd32768) >> 16);
      prod2  <= 63'(scaled) * 63'(rsqv_pkg::GAIN_Q32);
      x0     <= 31'((prod2 + 63'h80000000) >> 32);

      for (int i = 1; i < 4; i++) begin
        ang[i] <= ang[i-1];
        flp[i] <= flp[i-1];
        sd[i]  <= sd[i-1];
      end
    end
  end

  assign out_valid = vld[3];
  assign angle     = ang[3];
  assign flip      = flp[3];
  assign out_side  = sd[3];

endmodule

/* rtl/rsqv_cordic.sv */
// unrolled rotation-mode cordic, one iteration per register stage, then sign fix
// depends on rsqv_pkg
module rsqv_cordic #(
  parameter int RUNS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [30:0]                          x0,
  input  logic signed [15:0]                   angle,
  input  logic                                 flip,
  input  rsqv_pkg::side_t                      in_side,
  output logic                                 out_valid,
  output logic signed [rsqv_pkg::CORDIC_W-1:0] cos_out,
  output logic signed [rsqv_pkg::CORDIC_W-1:0] sin_out,
  output rsqv_pkg::side_t                      out_side
);

  localparam int W = rsqv_pkg::CORDIC_W;

  logic signed [W-1:0] xs  [RUNS+1];
  logic signed [W-1:0] ys  [RUNS+1];
  logic signed [W-1:0] zs  [RUNS+1];
  logic                fs  [RUNS+1];
  rsqv_pkg::side_t     sds [RUNS+1];
  logic [RUNS:0]       vs;

  assign xs[0]  = $signed(W'(x0));
  assign ys[0]  = '0;
  assign zs[0]  = $signed({{(W-32){angle[15]}}, angle, 16'h0000});
  assign fs[0]  = flip;
  assign sds[0] = in_side;
  assign vs[0]  = in_valid;

  for (genvar i = 0; i < RUNS; i++) begin : g_iter
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] da;

    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    assign da = $signed(W'(rsqv_pkg::ATAN_UNITS[i]));

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][W-1]) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - da;
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + da;
        end
        fs[i+1]  <= fs[i];
        sds[i+1] <= sds[i];
      end
    end
  end

  // undo the half-turn fold
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vs[RUNS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_out  <= fs[RUNS] ? -xs[RUNS] : xs[RUNS];
      sin_out  <= fs[RUNS] ? -ys[RUNS] : ys[RUNS];
      out_side <= sds[RUNS];
    end
  end

endmodule

/* rtl/rsqv_emit.sv */
// holds one sprite and sends its six vertices through a registered output
// depends on rsqv_pkg and the assertion macro header
`include "rotated_sprite_quad_vertices_top_assert.svh"

module rsqv_emit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [rsqv_pkg::CORDIC_W-1:0] cos_in,
  input  logic signed [rsqv_pkg::CORDIC_W-1:0] sin_in,
  input  rsqv_pkg::side_t                      in_side,
  output logic                                 in_take,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [135:0]                         m_tdata,
  output logic                                 m_tlast,
  output logic [2:0]                           m_tuser
);

  localparam int W = rsqv_pkg::CORDIC_W;
  localparam logic [2:0] VTX_0 = 3'd0;
  localparam logic [2:0] VTX_1 = 3'd1;
  localparam logic [2:0] VTX_2 = 3'd2;
  localparam logic [2:0] VTX_3 = 3'd3;
  localparam logic [2:0] VTX_4 = 3'd4;
  localparam logic [2:0] VTX_LAST = 3'd5;
  localparam logic [5:0] TEX_U = 6'b001110;  // bit k is u of vertex k
  localparam logic [5:0] TEX_V = 6'b100011;

  function automatic logic [31:0] sat32(input logic signed [W:0] v);
    logic [31:0] r;
    if (v > $signed((W+1)'(32'h7FFFFFFF))) begin
      r = 32'h7FFFFFFF;
    end else if (v < -$signed((W+1)'(33'h080000000))) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic                hold_v;
  logic [2:0]          cnt;
  logic signed [W-1:0] c_h;
  logic signed [W-1:0] s_h;
  rsqv_pkg::side_t     sd_h;

  logic [31:0]         vx;
  logic [31:0]         vy;
  logic [31:0]         vz;
  logic                tu;
  logic                tv;
  logic [31:0]         colour;

  logic                out_free;
  logic                step;
  logic signed [W-1:0] ox;
  logic signed [W-1:0] oy;
  logic signed [W:0]   sum_x;
  logic signed [W:0]   sum_y;

  always_comb begin
    out_free = !m_tvalid || m_tready;
    step     = hold_v && out_free;
    in_take  = !hold_v || (step && (cnt == VTX_LAST));

    case (cnt) inside
      VTX_0:        begin ox = c_h;  oy = s_h;  end
      VTX_1:        begin ox = s_h;  oy = -c_h; end
      VTX_2, VTX_3: begin ox = -c_h; oy = -s_h; end
      VTX_4:        begin ox = -s_h; oy = c_h;  end
      default:      begin ox = c_h;  oy = s_h;  end
    endcase

    sum_x = $signed((W+1)'(sd_h.cx)) + $signed({ox[W-1], ox});
    sum_y = $signed((W+1)'(sd_h.cy)) + $signed({oy[W-1], oy});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v   <= 1'b0;
      cnt      <= VTX_0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_free) begin
        m_tvalid <= hold_v;
      end
      if (step) begin
        cnt <= (cnt == VTX_LAST) ? VTX_0 : 3'(cnt + 3'd1);
      end
      if (in_valid && in_take) begin
        hold_v <= 1'b1;
      end else if (step && (cnt == VTX_LAST)) begin
        hold_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_take) begin
      c_h  <= cos_in;
      s_h  <= sin_in;
      sd_h <= in_side;
    end
    if (step) begin
      vx      <= sat32(sum_x);
      vy      <= sat32(sum_y);
      vz      <= sd_h.cz;
      tu      <= TEX_U[cnt];
      tv      <= TEX_V[cnt];
      colour  <= sd_h.colour;
      m_tuser <= cnt;
      m_tlast <= (cnt == VTX_LAST);
    end
  end

  assign m_tdata = {6'b000000, colour, tv, tu, vz, vy, vx};

  `RSQV_ASSERT(a_cnt_range, !hold_v || (cnt <= VTX_LAST), "vertex counter out of range")
  `RSQV_ASSERT(a_last_tag, !m_tvalid || (m_tlast == (m_tuser == VTX_LAST)), "tlast off sixth vertex")
  `RSQV_NEXT(a_step_shows, step, m_tvalid, "vertex stepped but output empty")

endmodule

/* rtl/rotated_sprite_quad_vertices_top.sv */
// path: prescale, cordic iteration stages, sign fix, vertex hold, output register
// throughput: one vertex word a cycle while m_tready is high; the six-vertex output
// sequencer sets this, the cordic pipeline takes a sprite each cycle when not stalled
// reset: synchronous, active high; clears all valid bits and the vertex counter
// depends on rsqv_pkg, rsqv_prescale, rsqv_cordic, rsqv_emit and the assertion header
`include "rotated_sprite_quad_vertices_top_assert.svh"

module rotated_sprite_quad_vertices_top #(
  parameter int CORDIC_STEPS = 16   // iterations, 8 to 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // centre_x[31:0] centre_y[63:32] centre_z[95:64] sprite_size[126:96]
  // rotation[142:127] rgba_colour[174:143] zero[175]
  input  logic [175:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // vertex_x[31:0] vertex_y[63:32] vertex_z[95:64] tex_u[96] tex_v[97]
  // vertex_colour[129:98] zero[135:130]
  output logic [135:0] m_tdata,
  output logic         m_tlast,   // last_vertex
  output logic [2:0]   m_tuser    // vertex_number
);

  // the arctangent table has 24 entries, more steps add nothing
  localparam int RUNS = (CORDIC_STEPS < rsqv_pkg::ATAN_COUNT) ?
                        CORDIC_STEPS : rsqv_pkg::ATAN_COUNT;
  localparam int W = rsqv_pkg::CORDIC_W;

  logic                en;
  rsqv_pkg::side_t     in_side;

  logic                pre_v;
  logic [30:0]         pre_x0;
  logic signed [15:0]  pre_angle;
  logic                pre_flip;
  rsqv_pkg::side_t     pre_side;

  logic                cor_v;
  logic signed [W-1:0] cor_c;
  logic signed [W-1:0] cor_s;
  rsqv_pkg::side_t     cor_side;

  logic                emit_take;

  // whole pipeline moves together; it only halts when the last stage holds a
  // sprite that the vertex sequencer cannot yet take
  assign en       = !cor_v || emit_take;
  assign s_tready = en;

  // centre and colour ride along beside the arithmetic
  assign in_side.cx     = $signed(s_tdata[31:0]);
  assign in_side.cy     = $signed(s_tdata[63:32]);
  assign in_side.cz     = s_tdata[95:64];
  assign in_side.colour = s_tdata[174:143];

  // size times 0.7 and cordic gain, angle lowered by an eighth turn and folded
  rsqv_prescale u_prescale (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s_tvalid),
    .sprite_size (s_tdata[126:96]),
    .rotation    (s_tdata[142:127]),
    .in_side     (in_side),
    .out_valid   (pre_v),
    .x0          (pre_x0),
    .angle       (pre_angle),
    .flip        (pre_flip),
    .out_side    (pre_side)
  );

  // one micro-rotation per stage gives size*cos and size*sin
  rsqv_cordic #(
    .RUNS (RUNS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pre_v),
    .x0        (pre_x0),
    .angle     (pre_angle),
    .flip      (pre_flip),
    .in_side   (pre_side),
    .out_valid (cor_v),
    .cos_out   (cor_c),
    .sin_out   (cor_s),
    .out_side  (cor_side)
  );

  // six vertices, saturating add of the centre, registered output word
  rsqv_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cor_v),
    .cos_in   (cor_c),
    .sin_in   (cor_s),
    .in_side  (cor_side),
    .in_take  (emit_take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // a stalled input can only come from a full last pipeline stage
  `RSQV_ASSERT(a_stall_cause, s_tready || cor_v, "input stalled with empty pipeline tail")

endmodule
